// File: hw/rtl/arpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the ARP cache and responder.
// ----------------------------------------------------------------------------
package arpc_pkg;

    // header checks for a received packet
    localparam logic [10:0] MIN_PACKET_LEN = 11'd28;
    localparam logic [15:0] HW_ETHERNET    = 16'h0001;
    localparam logic [15:0] PROTO_IPV4     = 16'h0800;
    localparam logic [7:0]  HW_LEN         = 8'd6;
    localparam logic [7:0]  PADDR_LEN      = 8'd4;
    localparam logic [15:0] OPCODE_REQUEST = 16'h0001;

    // item kinds on the input channel
    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // job queue between front and back, power of two
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic        op;
        logic [10:0] packet_length;
        logic [15:0] hw_type;
        logic [15:0] ptype;
        logic [7:0]  hw_addr_len;
        logic [7:0]  proto_addr_len;
        logic [15:0] arp_opcode;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [31:0] query_ip;
    } in_item_t;

    typedef struct packed {
        logic        packet_accepted;
        logic        reply_valid;
        logic [47:0] reply_dest_mac;
        logic [31:0] reply_dest_ip;
        logic        lookup_hit;
        logic [47:0] lookup_mac;
    } out_item_t;

    typedef enum logic [1:0] {
        JOB_REJECT,
        JOB_LEARN,
        JOB_LOOKUP
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic        reply;
        logic [31:0] ip;
        logic [47:0] mac;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } back_state_t;

endpackage

// File: hw/rtl/arp_cache_and_responder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_and_responder_top
// ARP cache with request responder: learns sender pairs from received
// packets, flags replies to requests for own_ip and answers lookups.
// ----------------------------------------------------------------------------
//  channel   signals                      direction  handshake
//  in        in_valid/in_ready/in_data    input      valid and ready
//  out       out_valid/out_ready/out_data output     valid and ready
//  cfg       cfg_wr_en/cfg_wr_data        input      write enable, no wait
//
//  a packet or lookup goes through the pop, the scan over the table
//  memory's single read port and the result
//  a rejected packet goes from the pop to the result, it skips the scan
//  a two-entry job queue lets input items be taken while the engine works
//  or a result waits on out_ready
//  reset clears the valid bits at once, no clearing pass
// ----------------------------------------------------------------------------
module arp_cache_and_responder_top
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);

    q_status_t q_status;
    logic      push;
    job_t      push_job;
    logic      pop;
    job_t      head;

    arpc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .q_status    (q_status),
        .push        (push),
        .push_job    (push_job)
    );

    arpc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    arpc_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: hw/rtl/arpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_front
// Takes input items, holds own_ip, checks the header and turns each item
// into a job for the cache engine.
// ----------------------------------------------------------------------------
module arpc_front
    import arpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    input  q_status_t   q_status,
    output logic        push,
    output job_t        push_job
);

    logic [31:0] own_ip_reg;
    logic [31:0] own_ip_next;
    logic        hdr_ok;
    logic        is_request;

    assign own_ip_next = cfg_wr_en ? cfg_wr_data : own_ip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg <= '0;
        end
        else
        begin
            own_ip_reg <= own_ip_next;
        end
    end

    assign hdr_ok = (in_data.packet_length >= MIN_PACKET_LEN) &&
                    (in_data.hw_type == HW_ETHERNET) &&
                    (in_data.ptype == PROTO_IPV4) &&
                    (in_data.hw_addr_len == HW_LEN) &&
                    (in_data.proto_addr_len == PADDR_LEN);

    // zero own_ip means no address, never answer
    assign is_request = (in_data.arp_opcode == OPCODE_REQUEST) &&
                        (own_ip_reg != '0) &&
                        (in_data.dst_ip == own_ip_reg);

    always_comb
    begin
        push_job.mac   = in_data.src_mac;
        push_job.reply = 1'b0;
        if (in_data.op == OP_LOOKUP)
        begin
            push_job.kind = JOB_LOOKUP;
            push_job.ip   = in_data.query_ip;
        end
        else if (hdr_ok)
        begin
            push_job.kind  = JOB_LEARN;
            push_job.ip    = in_data.src_ip;
            push_job.reply = is_request;
        end
        else
        begin
            push_job.kind = JOB_REJECT;
            push_job.ip   = in_data.src_ip;
        end
    end

    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;

endmodule

// File: hw/rtl/arpc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_queue
// Short job queue between the front and the cache engine.
// ----------------------------------------------------------------------------
module arpc_queue
    import arpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      head,
    output q_status_t status
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(Q_DEPTH);

    job_t             slot_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);

endmodule

// File: hw/rtl/arpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_back
// Cache engine: scans the table one entry a cycle for a matching IP and the
// first free slot, then learns the pair or answers the lookup.
// ----------------------------------------------------------------------------
module arpc_back
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_status_t q_status,
    input  job_t      head,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES);

    logic [31:0] entry_ip_mem  [TABLE_ENTRIES];
    logic [47:0] entry_mac_mem [TABLE_ENTRIES];

    back_state_t              state_reg;
    back_state_t              state_next;
    job_t                     job_reg;
    job_t                     job_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic [TABLE_ENTRIES-1:0] entry_valid_reg;
    logic [TABLE_ENTRIES-1:0] entry_valid_next;
    logic                     cmp_vld_reg;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic                     rd_vld_reg;
    logic [31:0]              rd_ip_reg;
    logic [47:0]              rd_mac_reg;
    logic                     found_match_reg;
    logic                     found_match_next;
    logic [IDX_W-1:0]         match_idx_reg;
    logic [IDX_W-1:0]         match_idx_next;
    logic [47:0]              match_mac_reg;
    logic [47:0]              match_mac_next;
    logic                     found_free_reg;
    logic                     found_free_next;
    logic [IDX_W-1:0]         free_idx_reg;
    logic [IDX_W-1:0]         free_idx_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    out_item_t                out_reg;
    out_item_t                out_next;

    logic             start;
    logic             rd_en;
    logic             finish;
    logic             out_free;
    logic             wr_en;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;
    logic             hit;
    logic             free_hit;

    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = (head.kind == JOB_REJECT) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // last compare has drained out of the read stage
                if ((cnt_reg == LAST_CNT) && !cmp_vld_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        pop    = 1'b0;
        start  = 1'b0;
        rd_en  = 1'b0;
        finish = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pop   = !q_status.empty;
                start = !q_status.empty;
            end
            ST_SCAN:
            begin
                rd_en = (cnt_reg != LAST_CNT);
            end
            ST_FINISH:
            begin
                finish = out_free;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        job_next = pop ? head : job_reg;
        rd_idx   = cnt_reg[IDX_W-1:0];
        if (start)
        begin
            cnt_next = '0;
        end
        else if (rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end

        hit      = cmp_vld_reg && rd_vld_reg && (rd_ip_reg == job_reg.ip);
        free_hit = cmp_vld_reg && !rd_vld_reg;

        found_match_next = found_match_reg;
        match_idx_next   = match_idx_reg;
        match_mac_next   = match_mac_reg;
        found_free_next  = found_free_reg;
        free_idx_next    = free_idx_reg;
        if (start)
        begin
            found_match_next = 1'b0;
            found_free_next  = 1'b0;
        end
        else
        begin
            // keep the lowest index of each kind
            if (hit && !found_match_reg)
            begin
                found_match_next = 1'b1;
                match_idx_next   = cmp_idx_reg;
                match_mac_next   = rd_mac_reg;
            end
            if (free_hit && !found_free_reg)
            begin
                found_free_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
            end
        end

        // same IP first, then the first free slot, else entry zero
        wr_en = finish && (job_reg.kind == JOB_LEARN);
        if (found_match_reg)
        begin
            wr_idx = match_idx_reg;
        end
        else if (found_free_reg)
        begin
            wr_idx = free_idx_reg;
        end
        else
        begin
            wr_idx = '0;
        end
        entry_valid_next = entry_valid_reg;
        if (wr_en)
        begin
            entry_valid_next[wr_idx] = 1'b1;
        end

        out_next = out_reg;
        if (finish)
        begin
            out_next                 = '0;
            out_next.packet_accepted = (job_reg.kind == JOB_LEARN);
            out_next.reply_valid     = (job_reg.kind == JOB_LEARN) && job_reg.reply;
            if ((job_reg.kind == JOB_LEARN) && job_reg.reply)
            begin
                out_next.reply_dest_mac = job_reg.mac;
                out_next.reply_dest_ip  = job_reg.ip;
            end
            if ((job_reg.kind == JOB_LOOKUP) && found_match_reg)
            begin
                out_next.lookup_hit = 1'b1;
                out_next.lookup_mac = match_mac_reg;
            end
        end
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            entry_valid_reg <= '0;
            cmp_vld_reg     <= 1'b0;
            found_match_reg <= 1'b0;
            found_free_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            entry_valid_reg <= entry_valid_next;
            cmp_vld_reg     <= rd_en;
            found_match_reg <= found_match_next;
            found_free_reg  <= found_free_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg       <= job_next;
        cmp_idx_reg   <= rd_idx;
        rd_vld_reg    <= entry_valid_reg[rd_idx];
        match_idx_reg <= match_idx_next;
        match_mac_reg <= match_mac_next;
        free_idx_reg  <= free_idx_next;
        out_reg       <= out_next;
    end

    // table memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_ip_mem[wr_idx]  <= job_reg.ip;
            entry_mac_mem[wr_idx] <= job_reg.mac;
        end
        if (rd_en)
        begin
            rd_ip_reg  <= entry_ip_mem[rd_idx];
            rd_mac_reg <= entry_mac_mem[rd_idx];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: hw/rtl/arpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module arpc_checker
    import arpc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input out_item_t   out_data
);

    // a stalled result holds
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data);
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result changed while stalled");

    // a result comes from a packet or a lookup, never both
    property p_one_kind;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.packet_accepted && out_data.lookup_hit);
    endproperty
    a_one_kind: assert property (p_one_kind)
        else $error("packet and lookup flags both set");

    property p_reply_needs_accept;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_data.reply_valid |-> out_data.packet_accepted;
    endproperty
    a_reply_needs_accept: assert property (p_reply_needs_accept)
        else $error("reply for a rejected packet");

    property p_reply_zero;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.reply_valid |->
            (out_data.reply_dest_mac == '0) && (out_data.reply_dest_ip == '0);
    endproperty
    a_reply_zero: assert property (p_reply_zero)
        else $error("reply address set without reply");

    property p_miss_zero;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.lookup_hit |-> (out_data.lookup_mac == '0);
    endproperty
    a_miss_zero: assert property (p_miss_zero)
        else $error("lookup mac set on a miss");

endmodule

bind arp_cache_and_responder_top arpc_checker u_checker (.*);
